// ===== hdl/lad_pkg.sv =====
// Shared codes, widths and the control type for the linear array deque.
package lad_pkg;

   localparam int CmdWidth    = 2;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 3;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 40;

   localparam logic [CmdWidth-1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_PUSH_REAR  = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [CmdWidth-1:0] CMD_POP_REAR   = 2'd3;

   localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
   localparam logic [StatusWidth-1:0] ST_FULL     = 3'd1;
   localparam logic [StatusWidth-1:0] ST_FRONT_BD = 3'd2;
   localparam logic [StatusWidth-1:0] ST_REAR_BD  = 3'd3;
   localparam logic [StatusWidth-1:0] ST_EMPTY    = 3'd4;

   localparam logic [ValueWidth-1:0] NO_VALUE = '1;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage

// ===== hdl/lad_ctrl.sv =====
// Controller state machine: sequences accept, execute and respond for each item.
module lad_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lad_pkg::ctl_type ctl
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      ctl.load = 1'b0;
      ctl.exec = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lad_datapath.sv =====
// Datapath: element memory, head/tail indices, command decode and result register.
module lad_datapath #(
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lad_pkg::ctl_type                    ctl,
   input  logic [lad_pkg::CmdWidth-1:0]        cmd,
   input  logic signed [lad_pkg::ValueWidth-1:0] push_value,
   output logic signed [lad_pkg::ValueWidth-1:0] pop_value,
   output logic [lad_pkg::StatusWidth-1:0]     status
);

   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AddrWidth-1:0] LastIdx = AddrWidth'(DEPTH - 1);

   logic [lad_pkg::ValueWidth-1:0] mem [DEPTH];

   logic [lad_pkg::CmdWidth-1:0]    cmd_ff;
   logic [lad_pkg::ValueWidth-1:0]  value_ff;
   logic [AddrWidth-1:0]            head_ff, head_in;
   logic [AddrWidth-1:0]            tail_ff, tail_in;
   logic                            empty_ff, empty_in;
   logic [lad_pkg::StatusWidth-1:0] status_ff, status_in;
   logic                            pop_ok_ff, pop_ok_in;
   logic [lad_pkg::ValueWidth-1:0]  rd_data_ff;
   logic                            wr_en;
   logic [AddrWidth-1:0]            wr_addr;
   logic [AddrWidth-1:0]            rd_addr;
   logic                            full;

   assign full = !empty_ff && (head_ff == '0) && (tail_ff == LastIdx);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = lad_pkg::ST_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      rd_addr   = head_ff;
      unique case (cmd_ff) inside
         lad_pkg::CMD_PUSH_FRONT, lad_pkg::CMD_PUSH_REAR: begin
            if (full) begin
               status_in = lad_pkg::ST_FULL;
            end else if (empty_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else if (cmd_ff == lad_pkg::CMD_PUSH_FRONT) begin
               if (head_ff == '0) begin
                  status_in = lad_pkg::ST_FRONT_BD;
               end else begin
                  head_in = head_ff - 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = head_ff - 1'b1;
               end
            end else begin
               if (tail_ff == LastIdx) begin
                  status_in = lad_pkg::ST_REAR_BD;
               end else begin
                  tail_in = tail_ff + 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = tail_ff + 1'b1;
               end
            end
         end
         default: begin
            if (empty_ff) begin
               status_in = lad_pkg::ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               rd_addr   = (cmd_ff == lad_pkg::CMD_POP_FRONT) ? head_ff : tail_ff;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (cmd_ff == lad_pkg::CMD_POP_FRONT) begin
                  head_in = head_ff + 1'b1;
               end else begin
                  tail_in = tail_ff - 1'b1;
               end
            end
         end
      endcase
   end

   // element memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (ctl.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd;
         value_ff <= push_value;
      end
      if (ctl.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (ctl.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   assign pop_value = pop_ok_ff ? rd_data_ff : lad_pkg::NO_VALUE;
   assign status    = status_ff;

endmodule

// ===== hdl/linear_array_deque_core.sv =====
// Top level of the linear array deque: stream ports around controller and datapath.
//
//   channel | dir | tdata fields (lsb first)           | tuser
//   req     | in  | cmd[1:0], push_value[33:2]          | -
//   rsp     | out | pop_value[31:0], status[34:32]      | -
//
// Each item is accepted, executed (index update plus one memory write or
// read, registered) and responded to before the next item is accepted.
// Reset empties the deque; memory contents are not cleared.
// A stalled rsp holds the result and blocks req until it is taken.
module linear_array_deque_core #(
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lad_pkg::ReqDataWidth-1:0]    req_tdata,  // cmd, push_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lad_pkg::RspDataWidth-1:0]    rsp_tdata   // pop_value, status
);

   lad_pkg::ctl_type                     ctl;
   logic signed [lad_pkg::ValueWidth-1:0] pop_value;
   logic [lad_pkg::StatusWidth-1:0]      status;

   lad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   lad_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cmd        (req_tdata[1:0]),
      .push_value (req_tdata[33:2]),
      .pop_value  (pop_value),
      .status     (status)
   );

   assign rsp_tdata = {5'b0, status, pop_value};

endmodule
